>>> design/edpd_pkg.sv
package edpd_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPEED_GAIN     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ACCEL_GAIN     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THROTTLE_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FF_OFFSET      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FORWARD_SPEED  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REVERSE_SPEED  = 3'd5;

    typedef enum logic [1:0] {
        OP_MANUAL   = 2'd0,
        OP_DISTANCE = 2'd1,
        OP_FOLLOW   = 2'd2,
        OP_IDLE     = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t             opcode;
        logic                new_command;
        logic signed [31:0]  encoder_count;
        logic signed [11:0]  steer_arg;
        logic signed [31:0]  target_arg;
        logic signed [15:0]  vision_angle;
    } in_word_t;

    typedef struct packed {
        logic signed [11:0]  steer_out;
        logic signed [7:0]   throttle_out;
        logic                distance_done;
        logic signed [31:0]  speed_estimate;
    } out_word_t;

endpackage

>>> design/encoder_velocity_pd_drive_unit.sv
// A word accepted on in_* is registered in the input stage and then in the result register,
// which drives out_*; with out_ready held high one word is accepted every cycle.
// The clock period is set by the single compute stage: a 17x33 and a 17x32 multiplier in
// parallel for the PD term and a split divide-by-12 on the encoder stencil sums.
// Reset (rst_n low, asynchronous): both stages empty, configuration back to its defaults,
// encoder history, estimates, distance base, done flag and held outputs cleared to zero.
module encoder_velocity_pd_drive_unit #(
    parameter int COUNT_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  edpd_pkg::in_word_t                    in_word,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output edpd_pkg::out_word_t                   out_word,
    input  logic                                  cfg_write,
    input  logic [edpd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [edpd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    // Width that holds the exact encoder difference, or the wrap width if wider.
    localparam int DIFF_BITS = (COUNT_BITS > 33) ? COUNT_BITS : 33;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // Truncating divide by 12 of a stencil sum. |x| is divided by 4 with a shift, then by 3
    // by splitting into 18-bit halves: since 2^18 = 1 (mod 3),
    // floor(a/3) = hi*(2^18-1)/3 + floor((hi+lo)/3), and the small quotient uses a
    // reciprocal multiply that is exact for sums below 2^20.
    function automatic logic signed [35:0] div12(input logic signed [37:0] x);
        logic [37:0] mag;
        logic [35:0] a;
        logic [17:0] hi;
        logic [17:0] lo;
        logic [18:0] sum;
        logic [39:0] sum_m;
        logic [35:0] q;
        mag   = x[37] ? (~x + 38'd1) : x;
        a     = mag[37:2];
        hi    = a[35:18];
        lo    = a[17:0];
        sum   = {1'b0, hi} + {1'b0, lo};
        sum_m = 40'(sum) * 40'd699051;
        q     = 36'(hi) * 36'd87381 + 36'(sum_m[39:21]);
        div12 = x[37] ? $signed(~q + 36'd1) : $signed(q);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [41:0] max_v;
        logic signed [41:0] min_v;
        max_v = 42'sh0_7FFF_FFFF;
        min_v = -42'sh0_8000_0000;
        if (v > max_v)
        begin
            sat32 = 32'sh7FFF_FFFF;
        end
        else if (v < min_v)
        begin
            sat32 = 32'sh8000_0000;
        end
        else
        begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic logic signed [37:0] sx38(input logic signed [31:0] v);
        sx38 = {{6{v[31]}}, v};
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]        speed_gain_reg;
    logic [15:0]        accel_gain_reg;
    logic [6:0]         throttle_limit_reg;
    logic signed [7:0]  ff_offset_reg;
    logic signed [15:0] forward_speed_reg;
    logic signed [15:0] reverse_speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_gain_reg     <= 16'd393;
            accel_gain_reg     <= 16'd6554;
            throttle_limit_reg <= 7'd30;
            ff_offset_reg      <= 8'sd4;
            forward_speed_reg  <= 16'sd1500;
            reverse_speed_reg  <= -16'sd4000;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                edpd_pkg::CFG_SPEED_GAIN:     speed_gain_reg     <= cfg_data;
                edpd_pkg::CFG_ACCEL_GAIN:     accel_gain_reg     <= cfg_data;
                edpd_pkg::CFG_THROTTLE_LIMIT: throttle_limit_reg <= cfg_data[6:0];
                edpd_pkg::CFG_FF_OFFSET:      ff_offset_reg      <= cfg_data[7:0];
                edpd_pkg::CFG_FORWARD_SPEED:  forward_speed_reg  <= cfg_data;
                edpd_pkg::CFG_REVERSE_SPEED:  reverse_speed_reg  <= cfg_data;
                default:                      ;  // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input stage and result register advance together
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic accept;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Stencil sums, formed at accept time
    //
    // The encoder history depends on nothing but the counts, so it shifts as each word is
    // accepted and the stencil sums ride in the input stage next to the word. The divide
    // then fits in the compute stage, and the new estimates are in place for the very next
    // word.
    // ------------------------------------------------------------------
    logic signed [31:0] hist_reg [4];   // newest first
    logic signed [37:0] t_x;
    logic signed [37:0] d1_x;
    logic signed [37:0] d2_x;
    logic signed [37:0] d3_x;
    logic signed [37:0] d4_x;
    logic signed [37:0] vel_sum_next;
    logic signed [37:0] acc_sum_next;

    assign t_x  = sx38(in_word.encoder_count);
    assign d1_x = sx38(hist_reg[0]);
    assign d2_x = sx38(hist_reg[1]);
    assign d3_x = sx38(hist_reg[2]);
    assign d4_x = sx38(hist_reg[3]);

    // -t + 8*d1 - 8*d3 + d4
    assign vel_sum_next = (d1_x <<< 3) - (d3_x <<< 3) + d4_x - t_x;
    // -t + 16*d1 - 30*d2 + 16*d3 - d4, with 30 = 32 - 2
    assign acc_sum_next = (d1_x <<< 4) + (d3_x <<< 4) - (d2_x <<< 5) + (d2_x <<< 1)
                        - t_x - d4_x;

    edpd_pkg::in_word_t s1_word_reg;
    logic signed [37:0] vel_sum_reg;
    logic signed [37:0] acc_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hist_reg[0]  <= '0;
            hist_reg[1]  <= '0;
            hist_reg[2]  <= '0;
            hist_reg[3]  <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                hist_reg[0]  <= in_word.encoder_count;
                hist_reg[1]  <= hist_reg[0];
                hist_reg[2]  <= hist_reg[1];
                hist_reg[3]  <= hist_reg[2];
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg <= in_word;
            vel_sum_reg <= vel_sum_next;
            acc_sum_reg <= acc_sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Compute stage state
    // ------------------------------------------------------------------
    logic signed [31:0] speed_est_reg;
    logic signed [31:0] accel_est_reg;
    logic signed [31:0] base_reg;
    logic               done_reg;
    logic signed [11:0] steer_hold_reg;
    logic signed [7:0]  throttle_hold_reg;

    // ------------------------------------------------------------------
    // New estimates: velocity is 50 * (sum / 12), acceleration is sum / 12
    // ------------------------------------------------------------------
    logic signed [35:0] vel_q;
    logic signed [35:0] acc_q;
    logic signed [41:0] vel_q_x;
    logic signed [41:0] vel_x50;
    logic signed [31:0] speed_est_next;
    logic signed [31:0] accel_est_next;

    assign vel_q   = div12(vel_sum_reg);
    assign acc_q   = div12(acc_sum_reg);
    assign vel_q_x = {{6{vel_q[35]}}, vel_q};
    assign vel_x50 = (vel_q_x <<< 5) + (vel_q_x <<< 4) + (vel_q_x <<< 1);

    assign speed_est_next = sat32(vel_x50);
    assign accel_est_next = sat32({{6{acc_q[35]}}, acc_q});

    // ------------------------------------------------------------------
    // PD throttle on the estimates left by the previous word
    // ------------------------------------------------------------------
    logic signed [31:0] speed_sel;
    logic signed [32:0] speed_x;
    logic signed [32:0] speed_bias;
    logic signed [23:0] speed_div512;
    logic signed [24:0] ff_term;
    logic signed [49:0] speed_err;
    logic signed [49:0] speed_gain_x;
    logic signed [49:0] accel_gain_x;
    logic signed [49:0] accel_est_x;
    logic signed [49:0] prod_p;
    logic signed [49:0] prod_a;
    logic signed [51:0] pd_sum;
    logic signed [51:0] pd_bias;
    logic signed [35:0] thr_q;
    logic signed [35:0] lim_pos;
    logic signed [35:0] lim_neg;
    logic signed [7:0]  drive_thr;

    always_comb
    begin
        if (s1_word_reg.opcode == edpd_pkg::OP_DISTANCE)
        begin
            speed_sel = (s1_word_reg.target_arg > 32'sd0)
                      ? {{16{forward_speed_reg[15]}}, forward_speed_reg}
                      : {{16{reverse_speed_reg[15]}}, reverse_speed_reg};
        end
        else
        begin
            speed_sel = s1_word_reg.target_arg;
        end
    end

    // speed / 512, truncated toward zero
    assign speed_x      = {speed_sel[31], speed_sel};
    assign speed_bias   = speed_x + (speed_sel[31] ? 33'sd511 : 33'sd0);
    assign speed_div512 = speed_bias[32:9];
    assign ff_term      = {{17{ff_offset_reg[7]}}, ff_offset_reg}
                        + {speed_div512[23], speed_div512};

    assign speed_err    = {{18{speed_sel[31]}}, speed_sel}
                        - {{18{speed_est_reg[31]}}, speed_est_reg};
    assign speed_gain_x = {34'd0, speed_gain_reg};
    assign accel_gain_x = {34'd0, accel_gain_reg};
    assign accel_est_x  = {{18{accel_est_reg[31]}}, accel_est_reg};
    assign prod_p       = speed_gain_x * speed_err;
    assign prod_a       = accel_gain_x * accel_est_x;

    assign pd_sum  = {{2{prod_p[49]}}, prod_p} - {{2{prod_a[49]}}, prod_a}
                   + ({{27{ff_term[24]}}, ff_term} <<< 16);
    // divide by 65536, truncated toward zero
    assign pd_bias = pd_sum + (pd_sum[51] ? 52'sd65535 : 52'sd0);
    assign thr_q   = pd_bias[51:16];

    assign lim_pos = {29'd0, throttle_limit_reg};
    assign lim_neg = -lim_pos;

    always_comb
    begin
        priority if (thr_q > lim_pos)
        begin
            drive_thr = lim_pos[7:0];
        end
        else if (thr_q < lim_neg)
        begin
            drive_thr = lim_neg[7:0];
        end
        else
        begin
            drive_thr = thr_q[7:0];
        end
    end

    // ------------------------------------------------------------------
    // Distance tracking: travelled count wraps at COUNT_BITS
    // ------------------------------------------------------------------
    logic signed [31:0]           base_eff;
    logic signed [DIFF_BITS-1:0]  enc_w;
    logic signed [DIFF_BITS-1:0]  base_w;
    logic signed [DIFF_BITS-1:0]  diff_w;
    logic signed [COUNT_BITS-1:0] moved;
    logic                         reached;

    assign base_eff = s1_word_reg.new_command ? s1_word_reg.encoder_count : base_reg;
    assign enc_w    = DIFF_BITS'(s1_word_reg.encoder_count);
    assign base_w   = DIFF_BITS'(base_eff);
    assign diff_w   = enc_w - base_w;
    assign moved    = diff_w[COUNT_BITS-1:0];
    assign reached  = ((s1_word_reg.target_arg > 32'sd0) && (moved > s1_word_reg.target_arg))
                   || ((s1_word_reg.target_arg < 32'sd0) && (moved < s1_word_reg.target_arg));

    // ------------------------------------------------------------------
    // Follow steering: vision angle / 16, truncated toward zero
    // ------------------------------------------------------------------
    logic signed [16:0] angle_bias;
    logic signed [11:0] follow_steer;

    assign angle_bias   = {s1_word_reg.vision_angle[15], s1_word_reg.vision_angle}
                        + (s1_word_reg.vision_angle[15] ? 17'sd15 : 17'sd0);
    assign follow_steer = angle_bias[15:4];

    // ------------------------------------------------------------------
    // Mode select
    // ------------------------------------------------------------------
    logic signed [11:0] steer_next;
    logic signed [7:0]  throttle_next;
    logic               done_next;
    logic signed [31:0] base_next;

    always_comb
    begin
        steer_next    = steer_hold_reg;
        throttle_next = throttle_hold_reg;
        done_next     = done_reg;
        base_next     = base_reg;
        unique case (s1_word_reg.opcode)
            edpd_pkg::OP_MANUAL:
            begin
                steer_next    = s1_word_reg.steer_arg;
                throttle_next = drive_thr;
            end
            edpd_pkg::OP_DISTANCE:
            begin
                // a new command restarts the run from the current count
                if (s1_word_reg.new_command)
                begin
                    done_next = 1'b0;
                    base_next = s1_word_reg.encoder_count;
                end
                steer_next = s1_word_reg.steer_arg;
                if (reached)
                begin
                    throttle_next = 8'sd0;
                    done_next     = 1'b1;
                end
                else
                begin
                    throttle_next = drive_thr;
                end
            end
            edpd_pkg::OP_FOLLOW:
            begin
                steer_next    = follow_steer;
                throttle_next = drive_thr;
            end
            edpd_pkg::OP_IDLE:
            begin
                // hold the last driven steering and throttle
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result register and state update, one word per advance
    // ------------------------------------------------------------------
    edpd_pkg::out_word_t out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            speed_est_reg     <= '0;
            accel_est_reg     <= '0;
            base_reg          <= '0;
            done_reg          <= 1'b0;
            steer_hold_reg    <= '0;
            throttle_hold_reg <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                speed_est_reg     <= speed_est_next;
                accel_est_reg     <= accel_est_next;
                base_reg          <= base_next;
                done_reg          <= done_next;
                steer_hold_reg    <= steer_next;
                throttle_hold_reg <= throttle_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_word_reg.steer_out      <= steer_next;
            out_word_reg.throttle_out   <= throttle_next;
            out_word_reg.distance_done  <= done_next;
            out_word_reg.speed_estimate <= speed_est_next;
        end
    end

    assign out_word = out_word_reg;

endmodule
